FILE: hdl/itch_pkg.sv
// Shared types, codes and lookup functions for the ITCH order message parser.
// Used by itch_frame_decode, itch_out_skid and itch_order_message_parser_core.
// No dependencies.
package itch_pkg;

    typedef enum logic [2:0] {
        KIND_ADD      = 3'd0,
        KIND_REPLACE  = 3'd1,
        KIND_DELETE   = 3'd2,
        KIND_CANCEL   = 3'd3,
        KIND_EXECUTED = 3'd4,
        KIND_NONE     = 3'd7
    } t_kind;

    localparam logic [7:0] TYPE_ADD      = 8'h41;  // 'A'
    localparam logic [7:0] TYPE_REPLACE  = 8'h55;  // 'U'
    localparam logic [7:0] TYPE_DELETE   = 8'h44;  // 'D'
    localparam logic [7:0] TYPE_CANCEL   = 8'h58;  // 'X'
    localparam logic [7:0] TYPE_EXECUTED = 8'h45;  // 'E'
    localparam logic [7:0] SIDE_BUY      = 8'h42;  // 'B'

    localparam int MASK_W = 5;
    localparam logic [MASK_W-1:0] MASK_RESET = 5'h1F;

    typedef struct packed {
        t_kind       kind;
        logic [47:0] event_time;
        logic [63:0] order_ref;
        logic [63:0] replacement_ref;
        logic        is_buy;
        logic [31:0] share_count;
        logic [31:0] limit_price;
        logic [63:0] symbol_hash;
        logic        truncated;
    } t_result;

    function automatic t_kind kind_of(input logic [7:0] msg_type);
        unique case (msg_type)
            TYPE_ADD:      kind_of = KIND_ADD;
            TYPE_REPLACE:  kind_of = KIND_REPLACE;
            TYPE_DELETE:   kind_of = KIND_DELETE;
            TYPE_CANCEL:   kind_of = KIND_CANCEL;
            TYPE_EXECUTED: kind_of = KIND_EXECUTED;
            default:       kind_of = KIND_NONE;
        endcase
    endfunction

    // Body length that covers the last decoded field of each kind.
    function automatic logic [5:0] needed_len(input t_kind kind);
        unique case (kind)
            KIND_ADD:      needed_len = 6'd36;
            KIND_REPLACE:  needed_len = 6'd35;
            KIND_DELETE:   needed_len = 6'd19;
            KIND_CANCEL:   needed_len = 6'd23;
            KIND_EXECUTED: needed_len = 6'd23;
            default:       needed_len = 6'd0;
        endcase
    endfunction

    // Powers of 31 used to weight each symbol byte in the hash.
    function automatic logic [34:0] pow31(input logic [2:0] idx);
        unique case (idx)
            3'd0: pow31 = 35'd1;
            3'd1: pow31 = 35'd31;
            3'd2: pow31 = 35'd961;
            3'd3: pow31 = 35'd29791;
            3'd4: pow31 = 35'd923521;
            3'd5: pow31 = 35'd28629151;
            3'd6: pow31 = 35'd887503681;
            3'd7: pow31 = 35'd27512614111;
            default: pow31 = 35'd0;
        endcase
    endfunction

    // Writes byte b into its big-endian lane of a field that occupies body
    // offsets start .. start+width-1; other positions leave acc unchanged.
    function automatic logic [63:0] place_byte(
        input logic [63:0] acc,
        input logic [15:0] pos,
        input int          start,
        input int          width,
        input logic [7:0]  b
    );
        logic [2:0]  lane;
        logic [16:0] p;
        place_byte = acc;
        p = {1'b0, pos};
        lane = 3'(start + width - 1 - int'(pos));
        if (p >= 17'(start) && p < 17'(start + width)) begin
            place_byte[{lane, 3'b000} +: 8] = b;
        end
    endfunction

endpackage

FILE: hdl/itch_order_message_parser_core.sv
// ITCH order message parser: one stream word per unstalled cycle in, decoded orders out.
// After its last body word a result is registered in r_out, or in the skid entry on a stall.
// Throughput: one word per cycle while not stalled; framing and decode are combinational.
// Input stalls while the skid entry is full, which needs a result held by an output stall.
// Synchronous active-low reset clears framing, accumulators and output valids;
// the type enable mask resets to all kinds enabled.
module itch_order_message_parser_core
    import itch_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [MASK_W-1:0] i_cfg_wdata,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [7:0]        i_stream_byte,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [2:0]        o_msg_kind,
    output logic [47:0]       o_event_time,
    output logic [63:0]       o_order_ref,
    output logic [63:0]       o_replacement_ref,
    output logic              o_is_buy,
    output logic [31:0]       o_share_count,
    output logic [31:0]       o_limit_price,
    output logic [63:0]       o_symbol_hash,
    output logic              o_truncated
);

    logic    take;
    logic    res_valid;
    logic    skid_full;
    t_result res;
    t_result out_res;

    assign take    = i_valid && !skid_full;
    assign o_stall = skid_full;

    itch_frame_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_byte      (i_stream_byte),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    itch_out_skid u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (res),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_data  (out_res),
        .o_full  (skid_full)
    );

    assign o_msg_kind        = out_res.kind;
    assign o_event_time      = out_res.event_time;
    assign o_order_ref       = out_res.order_ref;
    assign o_replacement_ref = out_res.replacement_ref;
    assign o_is_buy          = out_res.is_buy;
    assign o_share_count     = out_res.share_count;
    assign o_limit_price     = out_res.limit_price;
    assign o_symbol_hash     = out_res.symbol_hash;
    assign o_truncated       = out_res.truncated;

    // The skid entry only fills behind a held output word.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("skid entry occupied with no output word");

    a_kind_decoded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_msg_kind == KIND_ADD || o_msg_kind == KIND_REPLACE ||
                     o_msg_kind == KIND_DELETE || o_msg_kind == KIND_CANCEL ||
                     o_msg_kind == KIND_EXECUTED))
        else $error("output word carries an undecoded kind");

    a_repl_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_msg_kind != KIND_REPLACE) |-> (o_replacement_ref == 64'd0))
        else $error("replacement reference set on a non-replace word");

    a_add_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_msg_kind != KIND_ADD) |-> (o_symbol_hash == 64'd0 && !o_is_buy))
        else $error("add-only fields set on a non-add word");

endmodule

FILE: hdl/itch_frame_decode.sv
// Framing counters, field accumulators and the type enable register.
// Consumes one stream word per accepted cycle and flags a decoded result.
// Depends on itch_pkg.
module itch_frame_decode
    import itch_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  logic [7:0]        i_byte,
    input  logic              i_cfg_we,
    input  logic [MASK_W-1:0] i_cfg_wdata,
    output logic              o_res_valid,
    output t_result           o_res
);

    typedef enum logic [1:0] {
        PH_LEN_HI = 2'd0,
        PH_LEN_LO = 2'd1,
        PH_BODY   = 2'd2
    } t_phase;

    t_phase            r_phase, n_phase;
    logic [15:0]       r_len, n_len;
    logic [15:0]       r_pos, n_pos;
    logic [7:0]        r_type, n_type;
    logic [47:0]       r_time, n_time;
    logic [63:0]       r_ref, n_ref;
    logic [63:0]       r_ref2, n_ref2;
    logic [31:0]       r_qty, n_qty;
    logic [31:0]       r_price, n_price;
    logic [63:0]       r_hash, n_hash;
    logic              r_buy, n_buy;
    logic [MASK_W-1:0] r_mask;

    logic [7:0]  type_now;
    t_kind       kind;
    logic        last_byte;
    logic        kind_enabled;
    logic [63:0] time_wide;
    logic [63:0] qty_wide;
    logic [63:0] price_wide;
    logic [42:0] hash_term;
    logic        res_valid;

    always_comb begin
        n_phase   = r_phase;
        n_len     = r_len;
        n_pos     = r_pos;
        n_type    = r_type;
        n_time    = r_time;
        n_ref     = r_ref;
        n_ref2    = r_ref2;
        n_qty     = r_qty;
        n_price   = r_price;
        n_hash    = r_hash;
        n_buy     = r_buy;
        res_valid = 1'b0;

        type_now  = (r_pos == 16'd0) ? i_byte : r_type;
        kind      = kind_of(type_now);
        last_byte = ({1'b0, r_pos} + 17'd1) >= {1'b0, r_len};
        unique case (kind)
            KIND_ADD:      kind_enabled = r_mask[0];
            KIND_REPLACE:  kind_enabled = r_mask[1];
            KIND_DELETE:   kind_enabled = r_mask[2];
            KIND_CANCEL:   kind_enabled = r_mask[3];
            KIND_EXECUTED: kind_enabled = r_mask[4];
            default:       kind_enabled = 1'b0;
        endcase
        time_wide = '0;
        qty_wide  = '0;
        price_wide = '0;
        // Symbol byte at offset 24+k is weighted by 31^(7-k), i.e. the low
        // three position bits inverted.
        hash_term = {8'd0, pow31(~r_pos[2:0])} * {35'd0, i_byte};

        unique case (r_phase)
            PH_LEN_LO: begin
                // Second length word starts a fresh message.
                n_len   = {r_len[7:0], i_byte};
                n_pos   = '0;
                n_type  = '0;
                n_time  = '0;
                n_ref   = '0;
                n_ref2  = '0;
                n_qty   = '0;
                n_price = '0;
                n_hash  = '0;
                n_buy   = 1'b0;
                n_phase = ({r_len[7:0], i_byte} == 16'd0) ? PH_LEN_HI : PH_BODY;
            end
            PH_BODY: begin
                if (r_pos == 16'd0) begin
                    n_type = i_byte;
                end
                if (kind != KIND_NONE) begin
                    time_wide = place_byte({16'd0, r_time}, r_pos, 5, 6, i_byte);
                    n_time    = time_wide[47:0];
                    n_ref     = place_byte(r_ref, r_pos, 11, 8, i_byte);
                end
                unique case (kind)
                    KIND_ADD: begin
                        if (r_pos == 16'd19) begin
                            n_buy = (i_byte == SIDE_BUY);
                        end
                        qty_wide   = place_byte({32'd0, r_qty}, r_pos, 20, 4, i_byte);
                        n_qty      = qty_wide[31:0];
                        price_wide = place_byte({32'd0, r_price}, r_pos, 32, 4, i_byte);
                        n_price    = price_wide[31:0];
                        if (r_pos >= 16'd24 && r_pos < 16'd32) begin
                            n_hash = r_hash + {21'd0, hash_term};
                        end
                    end
                    KIND_REPLACE: begin
                        n_ref2     = place_byte(r_ref2, r_pos, 19, 8, i_byte);
                        qty_wide   = place_byte({32'd0, r_qty}, r_pos, 27, 4, i_byte);
                        n_qty      = qty_wide[31:0];
                        price_wide = place_byte({32'd0, r_price}, r_pos, 31, 4, i_byte);
                        n_price    = price_wide[31:0];
                    end
                    KIND_CANCEL, KIND_EXECUTED: begin
                        qty_wide = place_byte({32'd0, r_qty}, r_pos, 19, 4, i_byte);
                        n_qty    = qty_wide[31:0];
                    end
                    default: begin
                    end
                endcase
                if (last_byte) begin
                    n_phase   = PH_LEN_HI;
                    res_valid = kind_enabled;
                end else begin
                    n_pos = r_pos + 16'd1;
                end
            end
            default: begin
                // Expecting the first length word; a stray phase lands here too.
                n_len   = {8'd0, i_byte};
                n_phase = PH_LEN_LO;
            end
        endcase
    end

    always_comb begin
        o_res.kind            = kind;
        o_res.event_time      = n_time;
        o_res.order_ref       = n_ref;
        o_res.replacement_ref = n_ref2;
        o_res.is_buy          = n_buy;
        o_res.share_count     = n_qty;
        o_res.limit_price     = n_price;
        o_res.symbol_hash     = n_hash;
        o_res.truncated       = r_len < {10'd0, needed_len(kind)};
    end

    assign o_res_valid = i_take && res_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_LEN_HI;
            r_len   <= '0;
            r_pos   <= '0;
            r_type  <= '0;
            r_time  <= '0;
            r_ref   <= '0;
            r_ref2  <= '0;
            r_qty   <= '0;
            r_price <= '0;
            r_hash  <= '0;
            r_buy   <= 1'b0;
            r_mask  <= MASK_RESET;
        end else begin
            if (i_cfg_we) begin
                r_mask <= i_cfg_wdata;
            end
            if (i_take) begin
                r_phase <= n_phase;
                r_len   <= n_len;
                r_pos   <= n_pos;
                r_type  <= n_type;
                r_time  <= n_time;
                r_ref   <= n_ref;
                r_ref2  <= n_ref2;
                r_qty   <= n_qty;
                r_price <= n_price;
                r_hash  <= n_hash;
                r_buy   <= n_buy;
            end
        end
    end

endmodule

FILE: hdl/itch_out_skid.sv
// Result register with one skid entry between the decoder and the output port.
// The skid entry lets the decoder finish a word while a result is stalled.
// Depends on itch_pkg.
module itch_out_skid
    import itch_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    input  logic    i_stall,
    output logic    o_valid,
    output t_result o_data,
    output logic    o_full
);

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            // Upstream is held off while the skid entry is occupied.
            if (!i_stall) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (r_out_valid && i_stall) begin
                r_skid       <= i_data;
                r_skid_valid <= 1'b1;
            end else begin
                r_out       <= i_data;
                r_out_valid <= 1'b1;
            end
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;
    assign o_full  = r_skid_valid;

endmodule
